// ===== sv/rsdm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the regex star/dot matcher: command codes, symbol constants,
// the item and store-op structs. No dependencies.
package rsdm_pkg;

   localparam int MAX_ATOMS_DEFAULT = 32;

   localparam int SYM_W = 5;
   localparam logic [SYM_W-1:0] SYM_ANY         = 5'd26;
   localparam logic [SYM_W-1:0] SYM_LAST_LETTER = 5'd25;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_BEGIN  = 2'd2,
      CMD_CHAR   = 2'd3
   } cmd_type;

   // one input transaction as held in the input register
   typedef struct packed {
      cmd_type          cmd;
      logic [SYM_W-1:0] symbol;
      logic             repeat_req;
   } item_type;

   // pattern store update, issued when an item leaves the input register
   typedef struct packed {
      logic             clear;
      logic             append;
      logic [SYM_W-1:0] symbol;
      logic             repeat_req;
   } store_op_type;

endpackage

// ===== sv/regex_star_dot_matcher.sv =====
`timescale 1ns / 1ps
// Top level of the regex star/dot whole-string matcher.
// Depends on rsdm_pkg, rsdm_atom_store and rsdm_nfa_step.
//
//  channel | dir | ports                        | payload
//  --------+-----+------------------------------+-------------------------------
//  req     | in  | req_tvalid/tready/tdata/tuser| tuser: cmd; tdata: symbol, rep
//  rsp     | out | rsp_tvalid/tready/tdata      | tdata: matched, overflow
//
// Throughput is one transaction per clock unless a held result stalls the
// input register. A result passes these registers before rsp_tvalid rises:
// the input register captures the item, the result register the outcome;
// the NFA update sits between them.
// Reset (synchronous, active high) empties both registers, the pattern
// count, the active set and the overflow flag.
// A stalled result holds the input register only when that item also
// produces a result; clear and append items pass through regardless.
module regex_star_dot_matcher
   import rsdm_pkg::*;
#(
   parameter int MAX_ATOMS = MAX_ATOMS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [4:0] symbol, [5] repeat_req, [7:6] zero
   input  logic [1:0] req_tuser,   // [1:0] cmd
   // response stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] overflow, [7:2] zero
);

   localparam int CNT_W = $clog2(MAX_ATOMS + 1);
   localparam int SET_W = MAX_ATOMS + 1;

   // input register
   item_type in_ff;
   logic     in_valid_ff;

   // NFA position set: bit i = next to consume atom i, bit count = done
   logic [SET_W-1:0] active_ff, active_in;

   // result register
   logic       out_valid_ff;
   logic [1:0] out_data_ff;

   logic                            req_fire;
   logic                            item_fire;
   logic                            has_result;
   store_op_type                    store_op;
   logic [MAX_ATOMS-1:0][SYM_W-1:0] atom_symbol;
   logic [MAX_ATOMS-1:0]            atom_repeat;
   logic [CNT_W-1:0]                atom_count;
   logic                            overflow;
   logic [SET_W-1:0]                next_set;
   logic                            matched;

   assign has_result = (in_ff.cmd == CMD_BEGIN) || (in_ff.cmd == CMD_CHAR);
   // the item leaves when it has no result or the result register frees
   assign item_fire  = in_valid_ff && (!has_result || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || item_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff.cmd        <= cmd_type'(req_tuser);
         in_ff.symbol     <= req_tdata[4:0];
         in_ff.repeat_req <= req_tdata[5];
      end
   end

   assign store_op.clear      = item_fire && (in_ff.cmd == CMD_CLEAR);
   assign store_op.append     = item_fire && (in_ff.cmd == CMD_APPEND);
   assign store_op.symbol     = in_ff.symbol;
   assign store_op.repeat_req = in_ff.repeat_req;

   rsdm_atom_store #(
      .MAX_ATOMS (MAX_ATOMS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .op          (store_op),
      .atom_symbol (atom_symbol),
      .atom_repeat (atom_repeat),
      .atom_count  (atom_count),
      .overflow    (overflow)
   );

   rsdm_nfa_step #(
      .MAX_ATOMS (MAX_ATOMS)
   ) u_step (
      .begin_text  (in_ff.cmd == CMD_BEGIN),
      .ch          (in_ff.symbol),
      .active_set  (active_ff),
      .atom_symbol (atom_symbol),
      .atom_repeat (atom_repeat),
      .atom_count  (atom_count),
      .next_set    (next_set),
      .matched     (matched)
   );

   // a pattern change (clear or append) kills the running text
   always_comb begin
      unique case (in_ff.cmd)
         CMD_CLEAR, CMD_APPEND: active_in = '0;
         CMD_BEGIN, CMD_CHAR:   active_in = next_set;
         default:               active_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (item_fire) begin
         active_ff <= active_in;
      end
   end

   // result register; overflow reflects the flag before this item
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (item_fire && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire && has_result) begin
         out_data_ff <= {overflow, matched};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_data_ff};

   // checks

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      atom_count <= CNT_W'(MAX_ATOMS))
      else $error("atom count beyond capacity");

   a_clear_drops_overflow: assert property (@(posedge clock) disable iff (reset)
      store_op.clear |=> (!overflow && atom_count == '0))
      else $error("clear left overflow or atoms behind");

   a_full_append_sets_overflow: assert property (@(posedge clock) disable iff (reset)
      (store_op.append && atom_count == CNT_W'(MAX_ATOMS)) |=>
         (overflow && $stable(atom_count)))
      else $error("append at capacity not flagged");

   a_append_kills_text: assert property (@(posedge clock) disable iff (reset)
      store_op.append |=> (active_ff == '0))
      else $error("active set survived a pattern append");

   a_no_result_from_edit: assert property (@(posedge clock) disable iff (reset)
      (item_fire && !has_result && !(out_valid_ff && !rsp_tready)) |=> !rsp_tvalid)
      else $error("pattern edit produced a response");

endmodule

// ===== sv/rsdm_atom_store.sv =====
`timescale 1ns / 1ps
// Pattern atom store: symbol/repeat rows, fill count and sticky overflow.
// Depends on rsdm_pkg.
module rsdm_atom_store
   import rsdm_pkg::*;
#(
   parameter int MAX_ATOMS = MAX_ATOMS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_ATOMS + 1),
   localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  store_op_type                    op,
   output logic [MAX_ATOMS-1:0][SYM_W-1:0] atom_symbol,
   output logic [MAX_ATOMS-1:0]            atom_repeat,
   output logic [CNT_W-1:0]                atom_count,
   output logic                            overflow
);

   logic [MAX_ATOMS-1:0][SYM_W-1:0] symbol_ff;
   logic [MAX_ATOMS-1:0]            repeat_ff;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            overflow_ff, overflow_in;
   logic                            full;
   logic                            write_en;

   assign full     = (count_ff == CNT_W'(MAX_ATOMS));
   assign write_en = op.append && !full;

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (op.clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (op.append) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // rows hold no reset; only rows below the count are ever used
   always_ff @(posedge clock) begin
      if (write_en) begin
         symbol_ff[count_ff[IDX_W-1:0]] <= op.symbol;
         repeat_ff[count_ff[IDX_W-1:0]] <= op.repeat_req;
      end
   end

   assign atom_symbol = symbol_ff;
   assign atom_repeat = repeat_ff;
   assign atom_count  = count_ff;
   assign overflow    = overflow_ff;

endmodule

// ===== sv/rsdm_nfa_step.sv =====
`timescale 1ns / 1ps
// One NFA step: begin seeding or character advance, then forward closure
// through starred atoms by a log-depth prefix scan. Depends on rsdm_pkg.
module rsdm_nfa_step
   import rsdm_pkg::*;
#(
   parameter int MAX_ATOMS = MAX_ATOMS_DEFAULT,
   localparam int CNT_W = $clog2(MAX_ATOMS + 1),
   localparam int SET_W = MAX_ATOMS + 1,
   localparam int SCAN_STEPS = $clog2(SET_W)
) (
   input  logic                            begin_text,
   input  logic [SYM_W-1:0]                ch,
   input  logic [SET_W-1:0]                active_set,
   input  logic [MAX_ATOMS-1:0][SYM_W-1:0] atom_symbol,
   input  logic [MAX_ATOMS-1:0]            atom_repeat,
   input  logic [CNT_W-1:0]                atom_count,
   output logic [SET_W-1:0]                next_set,
   output logic                            matched
);

   logic [MAX_ATOMS-1:0] in_use;
   logic [SET_W-1:0]     seed;
   logic [SET_W-1:0]     prop;

   always_comb begin
      logic hit;
      seed = '0;
      prop = '0;
      for (int i = 0; i < MAX_ATOMS; i++) begin
         in_use[i] = (CNT_W'(i) < atom_count);
         hit = active_set[i] && in_use[i] &&
               ((atom_symbol[i] == SYM_ANY) ||
                ((ch <= SYM_LAST_LETTER) && (atom_symbol[i] == ch)));
         if (hit) begin
            if (atom_repeat[i]) begin
               seed[i] = 1'b1;
            end else begin
               seed[i+1] = 1'b1;
            end
         end
         // starred atom i in use lets position i carry into i+1
         prop[i+1] = atom_repeat[i] && in_use[i];
      end
      if (begin_text) begin
         seed = SET_W'(1);
      end
   end

   // prefix OR with propagate, like a carry-lookahead chain
   always_comb begin
      logic [SET_W-1:0] g;
      logic [SET_W-1:0] p;
      g = seed;
      p = prop;
      for (int k = 0; k < SCAN_STEPS; k++) begin
         g = g | (p & (g << (1 << k)));
         p = p & (p << (1 << k));
      end
      next_set = g;
   end

   assign matched = next_set[atom_count];

endmodule

// ===== dv/regex_star_dot_matcher_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for regex_star_dot_matcher: directed pattern/text cases,
// then random pattern-and-text runs under several idle/stall mixes.
// Depends on rsdm_pkg and the regex_star_dot_matcher RTL only.
module regex_star_dot_matcher_test;
   import rsdm_pkg::*;

   localparam int NATOMS      = MAX_ATOMS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 50;

   typedef struct packed {
      logic matched;
      logic overflow;
   } match_result_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [4:0] symbol, [5] repeat_req, [7:6] zero
   logic [1:0] req_tuser;   // [1:0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [0] matched, [1] overflow, [7:2] zero

   regex_star_dot_matcher DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Matcher state as the testbench tracks it.
   logic [SYM_W-1:0] patt_sym [NATOMS];
   logic             patt_rep [NATOMS];
   int               patt_len;
   logic [NATOMS:0]  live_pos;      // bit i: next to consume atom i; bit patt_len: done
   logic             patt_overflow;

   match_result_type match_expect[$];
   int               errors;
   int               items_sent;
   int               cycle_count;
   int               send_idle_pct;
   int               rsp_stall_pct;

   always #1 clock = ~clock;

   // Forward closure: a live starred atom may be skipped.
   function automatic logic [NATOMS:0] close_star(logic [NATOMS:0] s);
      for (int i = 0; i < NATOMS; i++)
         if (i < patt_len && s[i] && patt_rep[i])
            s[i+1] = 1'b1;
      return s;
   endfunction

   function automatic logic [NATOMS:0] step_char(logic [NATOMS:0] s, logic [SYM_W-1:0] ch);
      logic [NATOMS:0] nxt;
      logic            hit;
      nxt = '0;
      for (int i = 0; i < NATOMS; i++) begin
         hit = (patt_sym[i] == SYM_ANY) || (ch <= SYM_LAST_LETTER && patt_sym[i] == ch);
         if (i < patt_len && s[i] && hit) begin
            if (patt_rep[i])
               nxt[i] = 1'b1;
            else
               nxt[i+1] = 1'b1;
         end
      end
      return close_star(nxt);
   endfunction

   // Update tracked state for one accepted transaction; queue the result it causes.
   task automatic model_item(cmd_type c, logic [SYM_W-1:0] s, logic r);
      match_result_type res;
      unique case (c)
         CMD_CLEAR: begin
            patt_len      = 0;
            live_pos      = '0;
            patt_overflow = 1'b0;
         end
         CMD_APPEND: begin
            if (patt_len < NATOMS) begin
               patt_sym[patt_len] = s;
               patt_rep[patt_len] = r;
               patt_len++;
            end else begin
               patt_overflow = 1'b1;
            end
            live_pos = '0;   // pattern changed; a new begin is needed
         end
         default: begin
            if (c == CMD_BEGIN)
               live_pos = close_star({{NATOMS{1'b0}}, 1'b1});
            else
               live_pos = step_char(live_pos, s);
            res.matched  = live_pos[patt_len];
            res.overflow = patt_overflow;
            match_expect.push_back(res);
         end
      endcase
   endtask

   task automatic report_mismatch(string msg);
      if (errors < PRINT_CAP)
         $display("%0t ns mismatch: %s", $time, msg);
      errors++;
   endtask

   // Drive one transaction from a falling edge; returns at the accepting rising edge.
   task automatic send_item(cmd_type c, logic [SYM_W-1:0] s, logic r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {2'b00, r, s};
      do @(posedge clock); while (!req_tready);
      model_item(c, s, r);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (match_expect.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [SYM_W-1:0] any_sym();
      return SYM_W'($urandom_range(31));
   endfunction

   // Begin a text and feed characters that walk the current pattern;
   // some characters are replaced at random so near misses show up too.
   task automatic run_text(int mutate_pct);
      int               reps;
      int               len;
      logic [SYM_W-1:0] ch;
      len = patt_len;
      send_item(CMD_BEGIN, any_sym(), 1'($urandom_range(1)));
      for (int i = 0; i < len; i++) begin
         reps = patt_rep[i] ? $urandom_range(3) : 1;
         for (int k = 0; k < reps; k++) begin
            ch = (patt_sym[i] == SYM_ANY) ? any_sym() : patt_sym[i];
            if ($urandom_range(99) < mutate_pct)
               ch = any_sym();
            send_item(CMD_CHAR, ch, 1'($urandom_range(1)));
         end
      end
      if ($urandom_range(9) == 0)
         send_item(CMD_CHAR, any_sym(), 1'($urandom_range(1)));
   endtask

   // ---- test tasks ----

   // Characters with no begin, then the empty pattern.
   task automatic test_empty_pattern();
      send_item(CMD_CHAR, 5'd0, 1'b0);        // no begin yet: never matches
      send_item(CMD_BEGIN, 5'd31, 1'b1);      // empty pattern matches empty text
      send_item(CMD_CHAR, 5'd0, 1'b1);        // ...and nothing longer
      send_item(CMD_CHAR, 5'd31, 1'b0);
   endtask

   // Letters, any-character, stars, out-of-alphabet symbols on both sides.
   task automatic test_atoms();
      send_item(CMD_CLEAR, 5'd31, 1'b1);
      send_item(CMD_APPEND, 5'd0, 1'b0);      // a
      send_item(CMD_APPEND, SYM_ANY, 1'b1);   // .*
      send_item(CMD_APPEND, 5'd1, 1'b0);      // b
      send_item(CMD_BEGIN, 5'd0, 1'b0);
      send_item(CMD_CHAR, 5'd0, 1'b0);
      send_item(CMD_CHAR, 5'd1, 1'b0);
      send_item(CMD_CHAR, 5'd25, 1'b0);
      send_item(CMD_CHAR, 5'd1, 1'b0);
      // append after begin kills the text
      send_item(CMD_APPEND, 5'd31, 1'b1);     // unmatchable symbol, starred
      send_item(CMD_CHAR, 5'd1, 1'b0);
      send_item(CMD_BEGIN, 5'd0, 1'b0);
      send_item(CMD_CHAR, 5'd0, 1'b1);
      send_item(CMD_CHAR, 5'd1, 1'b0);
      send_item(CMD_CHAR, 5'd31, 1'b0);       // text symbol 31 vs atom 31: no match
      // any-character accepts symbols above the alphabet
      send_item(CMD_CLEAR, 5'd0, 1'b0);
      send_item(CMD_APPEND, SYM_ANY, 1'b0);
      send_item(CMD_BEGIN, 5'd0, 1'b0);
      send_item(CMD_CHAR, 5'd27, 1'b0);
      send_item(CMD_CHAR, 5'd26, 1'b0);
      // starred last letter
      send_item(CMD_CLEAR, 5'd0, 1'b0);
      send_item(CMD_APPEND, SYM_LAST_LETTER, 1'b1);
      send_item(CMD_BEGIN, 5'd0, 1'b0);
      send_item(CMD_CHAR, SYM_LAST_LETTER, 1'b0);
      send_item(CMD_CHAR, 5'd0, 1'b0);
   endtask

   // Fill the store, push past it, then check clear drops the sticky flag.
   task automatic test_overflow();
      send_item(CMD_CLEAR, 5'd0, 1'b0);
      for (int i = 0; i < NATOMS + 2; i++)
         send_item(CMD_APPEND, SYM_ANY, 1'($urandom_range(1)));
      run_text(0);
      send_item(CMD_CLEAR, 5'd0, 1'b0);
      send_item(CMD_BEGIN, 5'd0, 1'b0);
   endtask

   // Mostly well-formed pattern+text runs, some raw noise.
   task automatic test_random(int quota);
      int               stop_at;
      int               len;
      int               p;
      logic [SYM_W-1:0] s;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 3)
            wait_drained();
         if ($urandom_range(99) < 80) begin
            send_item(CMD_CLEAR, any_sym(), 1'($urandom_range(1)));
            len = ($urandom_range(99) < 5) ? $urandom_range(NATOMS - 2, NATOMS + 4)
                                           : $urandom_range(6);
            for (int i = 0; i < len; i++) begin
               p = $urandom_range(99);
               if (p < 15)
                  s = SYM_ANY;
               else if (p < 20)
                  s = SYM_W'($urandom_range(27, 31));
               else if (p < 25)
                  s = any_sym();
               else
                  s = SYM_W'($urandom_range(3));   // small alphabet: more matches
               send_item(CMD_APPEND, s, 1'($urandom_range(1)));
            end
            repeat ($urandom_range(1, 3))
               run_text(($urandom_range(1) == 0) ? 0 : 10);
         end else begin
            repeat ($urandom_range(1, 5))
               send_item(cmd_type'($urandom_range(3)), any_sym(), 1'($urandom_range(1)));
         end
      end
   endtask

   // ---- result checker and watchdog ----

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin : check_results
      match_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (match_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected result tdata=%h", rsp_tdata));
         end else begin
            want = match_expect.pop_front();
            if (rsp_tdata[0] !== want.matched)
               report_mismatch($sformatf("matched got %b want %b", rsp_tdata[0], want.matched));
            if (rsp_tdata[1] !== want.overflow)
               report_mismatch($sformatf("overflow got %b want %b",
                                         rsp_tdata[1], want.overflow));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---- sequence ----

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_CLEAR;
      rsp_tready    = 1'b0;
      errors        = 0;
      items_sent    = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      patt_len      = 0;
      live_pos      = '0;
      patt_overflow = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_atoms();
      test_overflow();
      wait_drained();

      // no idling, sender idle, receiver stall, both
      test_random(420);
      wait_drained();
      send_idle_pct = 84;
      test_random(420);
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 84;
      test_random(420);
      wait_drained();
      send_idle_pct = 21;
      rsp_stall_pct = 21;
      test_random(420);

      wait_drained();
      repeat (8) @(negedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
